// ----- rtl/cbsf_pkg.sv -----
// Shared types and constants for the CRC bit-stuffing framer.
// Beat payload structs, bit kind codes and configuration register indexes.
// No dependencies.
package cbsf_pkg;

    localparam int CNT_W      = 6;   // counters for CRC bits, flag bits, results
    localparam int OUT_LIMIT  = 32;  // most results one beat may cause
    localparam int FLAG_PAT_W = 8;   // bits held in flag_pattern
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_STUFF = 2'd1;
    localparam logic [1:0] KIND_CRC   = 2'd2;
    localparam logic [1:0] KIND_FLAG  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_DEGREE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STUFF_RUN    = 3'd4;

    typedef struct packed {
        logic action;
        logic data_bit;
    } in_item_t;

    typedef struct packed {
        logic       line_bit;
        logic [1:0] bit_kind;
        logic       last_of_run;
    } out_item_t;

endpackage

// ----- rtl/crc_bit_stuffing_framer.sv -----
// Top level of the CRC bit-stuffing framer: sequencer, CRC, stuffing, output beat register.
// Depends on cbsf_pkg.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat per message bit
//     (action 0) or an end-of-message mark (action 1).
//   out channel (out_valid/out_ready/out_data): one beat per line bit, with
//     its kind and last_of_run set on the final beat caused by an input beat.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//     always ready; write only while the framer is idle.
// Path: an accepted beat is first held in the sequencer registers, and its first
//   line bit is then registered into the output register.
// Throughput: one line bit per cycle while out_ready is high. A data bit gives
//   its line bit, after the opening flag bits if it starts a frame, and a stuffed
//   zero when the run is reached. An end beat gives CRC bits, stuffed zeros and
//   closing flag bits, at most 32 line bits. The next input beat is taken in the
//   cycle that the current beat's last line bit moves into the output register.
// Reset: configuration returns to x^3+x+1, flag 0111110, stuff after five
//   ones; the framer is idle with a zero remainder.
// Stall: while out_ready is low the output register holds its beat, the
//   sequencer holds, and in_ready drops once a beat is in progress.
module crc_bit_stuffing_framer #(
    parameter int MAX_CRC_BITS  = 16,
    parameter int MAX_FLAG_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cbsf_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cbsf_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbsf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cbsf_pkg::*;

    localparam int CW = MAX_CRC_BITS;

    typedef enum logic [2:0] {
        P_IDLE,
        P_OFLAG,
        P_DATA,
        P_STUFF,
        P_CRC,
        P_CFLAG
    } phase_t;

    // configuration
    logic [15:0] crc_poly_reg;
    logic [4:0]  crc_degree_reg;
    logic [7:0]  flag_pattern_reg;
    logic [3:0]  flag_length_reg;
    logic [2:0]  stuff_run_reg;

    // framer state
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [CW-1:0]    crc_reg, crc_next;
    logic [2:0]       ones_reg, ones_next;
    logic             in_frame_reg, in_frame_next;
    logic             end_reg, end_next;
    logic             bit_reg, bit_next;

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;
    out_item_t        res;

    // derived configuration
    logic [CNT_W-1:0] deg_eff;
    logic [CNT_W-1:0] flen_eff;
    logic [CW-1:0]    deg_mask;
    logic [CW-1:0]    top_onehot;
    logic [31:0]      poly_wide;
    logic [CW-1:0]    poly_w;

    // sequencer signals
    logic             emit;
    logic             last;
    logic             hit_limit;
    phase_t           follow;
    logic [CNT_W-1:0] follow_cnt;
    logic             pay_bit;
    logic [2:0]       ones_inc;
    logic             stuff_now;
    logic [2:0]       ones_pay;
    logic             crc_top;
    logic             fb;
    logic [CW-1:0]    crc_shift;
    logic [CW-1:0]    crc_mid;
    logic [2:0]       ones_mid;
    logic             frame_mid;
    logic             flag_bit;
    logic             accept;

    always_comb
    begin
        deg_eff = ({1'b0, crc_degree_reg} > CNT_W'(MAX_CRC_BITS))
                  ? CNT_W'(MAX_CRC_BITS) : {1'b0, crc_degree_reg};
        flen_eff = ({2'b00, flag_length_reg} > CNT_W'(MAX_FLAG_BITS))
                   ? CNT_W'(MAX_FLAG_BITS) : {2'b00, flag_length_reg};
        for (int i = 0; i < CW; i++)
        begin
            deg_mask[i] = (CNT_W'(i) < deg_eff);
        end
        top_onehot = deg_mask & ~(deg_mask >> 1);
        poly_wide  = {16'd0, crc_poly_reg};
        poly_w     = poly_wide[CW-1:0] & deg_mask;
    end

    // flag bit at position cnt_reg, zero above the pattern register
    assign flag_bit = (cnt_reg < CNT_W'(FLAG_PAT_W)) ? flag_pattern_reg[cnt_reg[2:0]] : 1'b0;

    // payload bit: data bit or top remainder bit
    assign crc_top   = |(crc_reg & top_onehot);
    assign pay_bit   = (phase_reg == P_CRC) ? crc_top : bit_reg;
    assign ones_inc  = pay_bit ? ((ones_reg == 3'd7) ? 3'd7 : ones_reg + 3'd1) : 3'd0;
    assign stuff_now = (stuff_run_reg != 3'd0) && (ones_inc == stuff_run_reg);
    assign ones_pay  = stuff_now ? 3'd0 : ones_inc;

    // remainder update for a data bit; CRC phase shifts the remainder out
    assign fb        = crc_top ^ bit_reg;
    assign crc_shift = (crc_reg << 1) & deg_mask;

    assign emit      = (phase_reg != P_IDLE) && (!out_valid_reg || out_ready);
    assign hit_limit = (emit_cnt_reg == CNT_W'(OUT_LIMIT - 1));

    always_comb
    begin
        res        = '0;
        follow     = P_IDLE;
        follow_cnt = cnt_reg;
        unique case (phase_reg)
            P_OFLAG:
            begin
                res.line_bit = flag_bit;
                res.bit_kind = KIND_FLAG;
                if (cnt_reg == '0)
                begin
                    follow = P_DATA;
                end
                else
                begin
                    follow     = P_OFLAG;
                    follow_cnt = cnt_reg - CNT_W'(1);
                end
            end
            P_DATA:
            begin
                res.line_bit = bit_reg;
                res.bit_kind = KIND_DATA;
                follow       = stuff_now ? P_STUFF : P_IDLE;
            end
            P_STUFF:
            begin
                res.line_bit = 1'b0;
                res.bit_kind = KIND_STUFF;
                if (!end_reg)
                begin
                    follow = P_IDLE;
                end
                else if (cnt_reg != '0)
                begin
                    follow = P_CRC;
                end
                else if (flen_eff != '0)
                begin
                    follow     = P_CFLAG;
                    follow_cnt = flen_eff - CNT_W'(1);
                end
            end
            P_CRC:
            begin
                res.line_bit = crc_top;
                res.bit_kind = KIND_CRC;
                follow_cnt   = cnt_reg - CNT_W'(1);
                if (stuff_now)
                begin
                    follow = P_STUFF;
                end
                else if (follow_cnt != '0)
                begin
                    follow = P_CRC;
                end
                else if (flen_eff != '0)
                begin
                    follow     = P_CFLAG;
                    follow_cnt = flen_eff - CNT_W'(1);
                end
            end
            P_CFLAG:
            begin
                res.line_bit = flag_bit;
                res.bit_kind = KIND_FLAG;
                if (cnt_reg != '0)
                begin
                    follow     = P_CFLAG;
                    follow_cnt = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                follow = P_IDLE;
            end
        endcase
        last            = hit_limit || (follow == P_IDLE);
        res.last_of_run = last;
    end

    assign in_ready = (phase_reg == P_IDLE) || (emit && last);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        end_next      = end_reg;
        bit_next      = bit_reg;
        crc_mid       = crc_reg;
        ones_mid      = ones_reg;
        frame_mid     = in_frame_reg;

        // advance the beat in progress
        if (emit)
        begin
            emit_cnt_next = emit_cnt_reg + CNT_W'(1);
            phase_next    = last ? P_IDLE : follow;
            cnt_next      = follow_cnt;
            if (phase_reg == P_DATA)
            begin
                ones_mid = ones_pay;
                crc_mid  = crc_shift ^ (fb ? poly_w : '0);
            end
            else if (phase_reg == P_CRC)
            begin
                ones_mid = ones_pay;
                crc_mid  = crc_shift;
            end
            if (last && end_reg)
            begin
                crc_mid   = '0;
                ones_mid  = 3'd0;
                frame_mid = 1'b0;
            end
        end

        crc_next      = crc_mid;
        ones_next     = ones_mid;
        in_frame_next = frame_mid;

        // start a new beat on top of what the last one left
        if (accept)
        begin
            end_next      = in_data.action;
            bit_next      = in_data.data_bit;
            emit_cnt_next = '0;
            phase_next    = P_IDLE;
            if (!in_data.action)
            begin
                phase_next = P_DATA;
                if (!frame_mid)
                begin
                    crc_next      = '0;
                    ones_next     = 3'd0;
                    in_frame_next = 1'b1;
                    if (flen_eff != '0)
                    begin
                        phase_next = P_OFLAG;
                        cnt_next   = flen_eff - CNT_W'(1);
                    end
                end
            end
            else if (frame_mid)
            begin
                if (deg_eff != '0)
                begin
                    phase_next = P_CRC;
                    cnt_next   = deg_eff;
                end
                else if (flen_eff != '0)
                begin
                    phase_next = P_CFLAG;
                    cnt_next   = flen_eff - CNT_W'(1);
                end
                else
                begin
                    // close a frame that sends nothing
                    crc_next      = '0;
                    ones_next     = 3'd0;
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            cnt_reg       <= '0;
            emit_cnt_reg  <= '0;
            crc_reg       <= '0;
            ones_reg      <= 3'd0;
            in_frame_reg  <= 1'b0;
            end_reg       <= 1'b0;
            bit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            crc_reg       <= crc_next;
            ones_reg      <= ones_next;
            in_frame_reg  <= in_frame_next;
            end_reg       <= end_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            // output beat payload
            if (emit)
            begin
                out_data_reg <= res;
            end
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg     <= 16'd3;
            crc_degree_reg   <= 5'd3;
            flag_pattern_reg <= 8'd62;
            flag_length_reg  <= 4'd7;
            stuff_run_reg    <= 3'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CRC_POLY:     crc_poly_reg     <= cfg_data;
                REG_CRC_DEGREE:   crc_degree_reg   <= cfg_data[4:0];
                REG_FLAG_PATTERN: flag_pattern_reg <= cfg_data[7:0];
                REG_FLAG_LENGTH:  flag_length_reg  <= cfg_data[3:0];
                REG_STUFF_RUN:    stuff_run_reg    <= cfg_data[2:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sim/crc_bit_stuffing_framer_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the CRC bit-stuffing framer: follows register writes, predicts the
// line bits of every accepted input beat and compares them with the output channel.
// Depends on cbsf_pkg.
module crc_bit_stuffing_framer_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  cbsf_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  cbsf_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cbsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbsf_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import cbsf_pkg::*;

    localparam int CRC_BITS_MAX  = 16;
    localparam int FLAG_BITS_MAX = 8;

    logic [15:0] poly_r;
    logic [4:0]  degree_r;
    logic [7:0]  pattern_r;
    logic [3:0]  flag_len_r;
    logic [2:0]  stuff_run_r;

    logic [15:0] remainder;
    logic [2:0]  ones_run;
    logic        frame_open;

    out_item_t   line_bit_q[$];   // expected line bits, oldest first
    out_item_t   beat_bits[$];    // line bits of the beat being predicted

    // Past the per-beat limit, drop.
    task automatic emit_bit(input logic b, input logic [1:0] kind);
        out_item_t item;
        if (beat_bits.size() < OUT_LIMIT) begin
            item.line_bit    = b;
            item.bit_kind    = kind;
            item.last_of_run = 1'b0;
            beat_bits.push_back(item);
        end
    endtask

    task automatic emit_flag();
        int len;
        len = (flag_len_r > FLAG_BITS_MAX) ? FLAG_BITS_MAX : int'(flag_len_r);
        for (int i = len - 1; i >= 0; i--)
            emit_bit(pattern_r[i], KIND_FLAG);
    endtask

    task automatic emit_payload(input logic b, input logic [1:0] kind);
        emit_bit(b, kind);
        if (b) begin
            if (ones_run != 3'd7)
                ones_run++;
        end
        else
            ones_run = '0;
        if (stuff_run_r != '0 && ones_run == stuff_run_r) begin
            emit_bit(1'b0, KIND_STUFF);
            ones_run = '0;
        end
    endtask

    function automatic int crc_bits();
        return (degree_r > CRC_BITS_MAX) ? CRC_BITS_MAX : int'(degree_r);
    endfunction

    function automatic logic [15:0] crc_mask(input int d);
        logic [16:0] m;
        m = (17'd1 << d) - 17'd1;
        return m[15:0];
    endfunction

    task automatic fold_crc(input logic b);
        int          d;
        logic [15:0] m;
        logic        fb;
        d = crc_bits();
        m = crc_mask(d);
        if (d == 0)
            remainder = '0;
        else begin
            fb        = remainder[d-1] ^ b;
            remainder = (remainder << 1) & m;
            if (fb)
                remainder = remainder ^ (poly_r & m);
        end
    endtask

    task automatic frame_line_bits(input in_item_t beat);
        int          d;
        logic [15:0] rem;
        out_item_t   tail;
        beat_bits.delete();
        if (!beat.action) begin
            if (!frame_open) begin
                emit_flag();
                remainder  = '0;
                ones_run   = '0;
                frame_open = 1'b1;
            end
            emit_payload(beat.data_bit, KIND_DATA);
            fold_crc(beat.data_bit);
        end
        else if (frame_open) begin
            d   = crc_bits();
            rem = remainder & crc_mask(d);
            for (int i = d - 1; i >= 0; i--)
                emit_payload(rem[i], KIND_CRC);
            emit_flag();
            remainder  = '0;
            ones_run   = '0;
            frame_open = 1'b0;
        end
        if (beat_bits.size() > 0) begin
            tail             = beat_bits.pop_back();
            tail.last_of_run = 1'b1;
            beat_bits.push_back(tail);
        end
        foreach (beat_bits[i])
            line_bit_q.push_back(beat_bits[i]);
    endtask

    task automatic check_field(input string field, input logic [1:0] want,
                               input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n) begin
            poly_r      = 16'd3;
            degree_r    = 5'd3;
            pattern_r   = 8'd62;
            flag_len_r  = 4'd7;
            stuff_run_r = 3'd5;
            remainder   = '0;
            ones_run    = '0;
            frame_open  = 1'b0;
            line_bit_q.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CRC_POLY:     poly_r      = cfg_data[15:0];
                    REG_CRC_DEGREE:   degree_r    = cfg_data[4:0];
                    REG_FLAG_PATTERN: pattern_r   = cfg_data[7:0];
                    REG_FLAG_LENGTH:  flag_len_r  = cfg_data[3:0];
                    REG_STUFF_RUN:    stuff_run_r = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                frame_line_bits(in_data);
            if (out_valid && out_ready) begin
                if (line_bit_q.size() == 0) begin
                    $error("unexpected beat: line_bit %0d bit_kind %0d last_of_run %0d",
                           out_data.line_bit, out_data.bit_kind, out_data.last_of_run);
                    fail_count++;
                end
                else begin
                    want = line_bit_q.pop_front();
                    check_field("line_bit", want.line_bit, out_data.line_bit);
                    check_field("bit_kind", want.bit_kind, out_data.bit_kind);
                    check_field("last_of_run", want.last_of_run, out_data.last_of_run);
                end
            end
            pending = line_bit_q.size();
        end
    end

endmodule

// ----- sim/crc_bit_stuffing_framer_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the CRC bit-stuffing framer: clock, reset, beat and register
// stimulus, receiver back-pressure and the verdict.
// Depends on cbsf_pkg, crc_bit_stuffing_framer and crc_bit_stuffing_framer_checker.
module crc_bit_stuffing_framer_tb;
    import cbsf_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_req;

    always #10 clk = ~clk;

    crc_bit_stuffing_framer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crc_bit_stuffing_framer_checker i_checker (.*);

    // Called and returns at a falling edge; valid stays up for a following beat.
    task automatic send_beat(input logic action, input logic data_bit);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            in_data  <= in_item_t'(2'($urandom));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{action: action, data_bit: data_bit};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain, then give beats that cause no line bits (or a dropped tail) time to finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_setting(input logic [15:0] poly, input logic [4:0] deg,
                                 input logic [7:0] pat, input logic [3:0] flag_len,
                                 input logic [2:0] run);
        settle();
        cfg_write(REG_CRC_POLY, poly);
        cfg_write(REG_CRC_DEGREE, {11'($urandom), deg});
        cfg_write(REG_FLAG_PATTERN, {8'($urandom), pat});
        cfg_write(REG_FLAG_LENGTH, {12'($urandom), flag_len});
        cfg_write(REG_STUFF_RUN, {13'($urandom), run});
        // unused index, must change nothing
        cfg_write(CFG_IDX_W'(REG_STUFF_RUN + $urandom_range(1, 3)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int   stall_left;
        logic hold_seen;
        stall_left = 0;
        hold_seen  = 1'b0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_seen) begin
                hold_seen  = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin : stimulus
        int           sent;
        int           msg_len;
        int           ones_pct;
        logic [4:0]   deg;
        logic [3:0]   flag_len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 20;
        rx_idle_pct = 52;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: stuffing after five ones, CRC, end while idle.
        repeat (5) send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b0);

        // Degree and flag length above their maximum, stuff after every one: overflow.
        write_setting(16'hFFFF, 5'd31, 8'hFF, 4'd15, 3'd1);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b1);

        // No CRC, no flag, no stuffing: the ones count saturates.
        write_setting(16'h0000, 5'd0, 8'h00, 4'd0, 3'd0);
        repeat (7) send_beat(1'b0, 1'b1);
        // Change degree and run length inside the open frame.
        settle();
        cfg_write(REG_CRC_DEGREE, 16'd5);
        cfg_write(REG_STUFF_RUN, 16'd2);
        cfg_valid <= 1'b0;
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b0);

        for (int phase = 0; phase < 6; phase++) begin
            deg = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 16));
            flag_len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
            write_setting(16'($urandom), deg, 8'($urandom), flag_len,
                          3'($urandom_range(0, 7)));
            tx_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 52 : 0;
            rx_idle_pct = (phase < 2) ? 52 : (phase < 4) ? 20 : 0;
            // Stall the receiver long enough to back up the input.
            if (phase == 0)
                hold_req <= 1'b1;
            sent = 0;
            while (sent < 34) begin
                if ($urandom_range(0, 99) < 85) begin
                    msg_len  = $urandom_range(1, 10);
                    ones_pct = ($urandom_range(0, 1) != 0) ? 90 : 50;
                    for (int k = 0; k < msg_len; k++)
                        send_beat(1'b0, $urandom_range(0, 99) < ones_pct);
                    send_beat(1'b1, 1'($urandom));
                    sent += msg_len + 1;
                end
                else begin
                    send_beat(1'($urandom), 1'($urandom));
                    sent++;
                end
            end
        end
        send_beat(1'b1, 1'($urandom));

        in_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending != 0; n++)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (pending != 0)
            $error("%0d expected line bits never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("[crc_bit_stuffing_framer] OK");
        else
            $display("[crc_bit_stuffing_framer] ERROR");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("[crc_bit_stuffing_framer] ERROR");
        $finish;
    end

endmodule
